FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_RST(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_CLK(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/mfbp_pkg.sv
// Package for the MSB-first bit packer: widths and control/status types.
`default_nettype none

package mfbp_pkg;

  localparam int MAX_BITS = 64;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 3;
  localparam int WORK_W   = VALUE_W + BYTE_W;
  localparam int REM_W    = 7;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic has_byte;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/mfbp_if.sv
// Valid/ready channel interfaces for input items and output bytes.
`default_nettype none

interface mfbp_in_if;
  import mfbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [VALUE_W-1:0]   value;
  logic [COUNT_W-1:0]   bit_count;

  modport source (output valid, action, value, bit_count, input ready);
  modport sink   (input valid, action, value, bit_count, output ready);
endinterface

interface mfbp_out_if;
  import mfbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/mfbp_ctrl.sv
// Controller FSM: loads an item, then drains complete bytes one per cycle while the output slot is free.
`default_nettype none

module mfbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire mfbp_pkg::status_t status,
  output mfbp_pkg::cmd_t        cmd
);
  import mfbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.has_byte) begin
          cmd.emit = status.slot_free;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        item_ready = 1'b0;
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mfbp_datapath.sv
// Datapath: bit alignment, work shift register, remaining count, output register.
`default_nettype none

module mfbp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mfbp_pkg::cmd_t                cmd,
  input  wire logic                          action,
  input  wire logic [mfbp_pkg::VALUE_W-1:0]  value,
  input  wire logic [mfbp_pkg::COUNT_W-1:0]  bit_count,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [mfbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last,
  output mfbp_pkg::status_t                  status
);
  import mfbp_pkg::*;

  // work holds the pending bits left-aligned; bits past rem are always zero.
  logic [WORK_W-1:0]  work, work_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [COUNT_W-1:0] n_sat;
  logic [COUNT_W-1:0] shamt;
  logic [VALUE_W-1:0] aligned;
  logic [POS_W-1:0]   bit_pos;

  assign bit_pos = rem[POS_W-1:0];
  assign n_sat   = (bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count;
  assign shamt   = COUNT_W'(VALUE_W) - n_sat;
  // Shifting left by (64 - n) drops the unused high bits of value.
  assign aligned = value << shamt;

  assign status.has_byte  = (rem >= REM_W'(BYTE_W));
  assign status.slot_free = !out_valid || out_ready;

  always_comb begin
    work_next = work;
    rem_next  = rem;
    if (cmd.load) begin
      if (action == ACT_FLUSH) begin
        rem_next = (bit_pos != '0) ? REM_W'(BYTE_W) : '0;
      end else begin
        work_next = work | ({aligned, BYTE_W'(0)} >> bit_pos);
        rem_next  = REM_W'(bit_pos) + REM_W'(n_sat);
      end
    end else if (cmd.emit) begin
      work_next = work << BYTE_W;
      rem_next  = rem - REM_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
      rem  <= '0;
    end else begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= work[WORK_W-1 -: BYTE_W];
      out_last <= (rem < REM_W'(2 * BYTE_W));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: controller, datapath and channels.
`default_nettype none
`include "assert_macros.svh"

// Packs written bit fields MSB first into bytes and flushes a padded partial
// byte on request. An item is taken while the controller is idle. Each
// completed byte then moves into the output register, one per cycle. Once
// no full byte is left, the controller returns to idle. Leftover bits stay in
// the work register for the next item. An item completes 0 to 8 bytes.
// The one-byte output register sets the drain rate. Backpressure on it
// stretches the run.
module msb_first_bit_packer (
  input  wire logic   clk,
  input  wire logic   rst,
  mfbp_in_if.sink     item,
  mfbp_out_if.source  result
);
  import mfbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mfbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  mfbp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (item.action),
    .value     (item.value),
    .bit_count (item.bit_count),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_byte  (result.out_byte),
    .out_last  (result.last_of_run),
    .status    (status)
  );

  `ASSERT_RST(a_load_no_emit, clk, rst, (item.valid && item.ready) |-> !cmd.emit, "emit during load")
  `ASSERT_RST(a_emit_ok, clk, rst, cmd.emit |-> (status.has_byte && status.slot_free), "bad emit")
  `ASSERT_RST(a_emit_valid, clk, rst, cmd.emit |=> result.valid, "emit lost")
  `ASSERT_CLK(a_rst_clear, clk, rst |=> !result.valid, "output valid after reset")

endmodule

`default_nettype wire

FILE: dv/tb_msb_first_bit_packer.sv
// Testbench for the MSB-first bit packer: stimulus, packing predictor and byte checker.
module tb_msb_first_bit_packer;
  import mfbp_pkg::*;

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] bit_count;
  } pack_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_action = ACT_WRITE;
  logic [VALUE_W-1:0] in_value = '0;
  logic [COUNT_W-1:0] in_count = '0;
  logic               out_ready = 1'b0;

  mfbp_in_if  item_ch ();
  mfbp_out_if result_ch ();

  assign item_ch.valid     = in_valid;
  assign item_ch.action    = in_action;
  assign item_ch.value     = in_value;
  assign item_ch.bit_count = in_count;
  assign result_ch.ready   = out_ready;

  msb_first_bit_packer DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  pack_req_t    req_backlog[$];
  packed_byte_t expected_bytes[$];

  logic [BYTE_W-1:0] acc_byte = '0;
  int                acc_bits = 0;

  logic in_taken = 1'b0;
  int   mismatches = 0;
  int   reqs_taken = 0;
  int   flushes_taken = 0;
  int   bytes_checked = 0;

  int burst_left = 1;
  int gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [6:0]  stall_tick = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic queue_req(input logic act, input logic [VALUE_W-1:0] val,
                           input logic [COUNT_W-1:0] cnt);
    pack_req_t r;
    r.action = act;
    r.value = val;
    r.bit_count = cnt;
    req_backlog.push_back(r);
  endtask

  task automatic pack_bits(input pack_req_t r);
    packed_byte_t run[8];
    int n;
    int nbytes;
    nbytes = 0;
    if (r.action == ACT_FLUSH) begin
      if (acc_bits != 0) begin
        run[0].data = acc_byte;
        run[0].last = 1'b1;
        expected_bytes.push_back(run[0]);
        acc_byte = '0;
        acc_bits = 0;
      end
    end else begin
      n = (r.bit_count > MAX_BITS) ? MAX_BITS : int'(r.bit_count);
      for (int i = n - 1; i >= 0; i--) begin
        acc_byte[7 - acc_bits] = r.value[i];
        acc_bits++;
        if (acc_bits == 8) begin
          run[nbytes].data = acc_byte;
          run[nbytes].last = 1'b0;
          nbytes++;
          acc_byte = '0;
          acc_bits = 0;
        end
      end
      if (nbytes > 0) run[nbytes - 1].last = 1'b1;
      for (int j = 0; j < nbytes; j++) expected_bytes.push_back(run[j]);
    end
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    pack_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        r = req_backlog.pop_front();
        in_action <= r.action;
        in_value <= r.value;
        in_count <= r.bit_count;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a random 16-bit pattern, reloaded whenever the 7-bit tick counter wraps.
  always @(negedge clk) begin
    logic [15:0] pat;
    if (stall_tick == 0) begin
      case ($urandom_range(0, 3))
        0: pat = 16'hFFFF;
        1: pat = 16'($urandom) | 16'h0001;
        2: pat = 16'hFFFF ^ (16'h0001 << $urandom_range(0, 15));
        default: pat = 16'h0001 << $urandom_range(0, 15);
      endcase
      stall_pat <= pat;
    end
    out_ready <= stall_pat[stall_tick[3:0]];
    stall_tick <= stall_tick + 7'd1;
  end

  // Monitor: check each output transfer, then predict from each input transfer.
  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= item_ch.valid && item_ch.ready;
      if (result_ch.valid && result_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %02h (last_of_run %0b)", result_ch.out_byte,
                 result_ch.last_of_run);
          mismatches++;
        end else begin
          exp_b = expected_bytes.pop_front();
          bytes_checked++;
          if (result_ch.out_byte !== exp_b.data) begin
            $error("out_byte: expected %02h, got %02h", exp_b.data, result_ch.out_byte);
            mismatches++;
          end
          if (result_ch.last_of_run !== exp_b.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_b.last,
                   result_ch.last_of_run);
            mismatches++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        pack_bits('{item_ch.action, item_ch.value, item_ch.bit_count});
        reqs_taken++;
        if (item_ch.action == ACT_FLUSH) flushes_taken++;
      end
    end
  end

  initial begin
    logic               act;
    logic [VALUE_W-1:0] val;
    logic [COUNT_W-1:0] cnt;
    int                 sel;

    queue_req(ACT_WRITE, '1, 7'd0);
    queue_req(ACT_FLUSH, '0, 7'd0);
    queue_req(ACT_WRITE, 64'h1, 7'd1);
    queue_req(ACT_FLUSH, '0, 7'd0);
    queue_req(ACT_WRITE, 64'hA5, 7'd8);
    queue_req(ACT_WRITE, '1, 7'd64);
    queue_req(ACT_WRITE, 64'h0123_4567_89AB_CDEF, 7'd64);
    queue_req(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3);
    queue_req(ACT_WRITE, '0, 7'd0);
    queue_req(ACT_WRITE, '1, 7'd13);
    queue_req(ACT_FLUSH, '0, 7'd0);
    queue_req(ACT_FLUSH, '1, 7'd127);
    queue_req(ACT_WRITE, {$urandom, $urandom}, 7'd127);
    queue_req(ACT_WRITE, {$urandom, $urandom}, 7'd65);
    queue_req(ACT_WRITE, '0, 7'd7);
    queue_req(ACT_WRITE, '0, 7'd64);
    queue_req(ACT_FLUSH, '1, 7'd64);
    queue_req(ACT_WRITE, 64'h15, 7'd5);
    queue_req(ACT_WRITE, 64'h8000_0000_0000_0001, 7'd64);
    queue_req(ACT_FLUSH, '0, 7'd0);
    queue_req(ACT_WRITE, '1, 7'd96);
    queue_req(ACT_WRITE, 64'h1, 7'd1);
    queue_req(ACT_FLUSH, 64'h5555_5555_5555_5555, 7'd42);

    for (int k = 0; k < 410; k++) begin
      act = ($urandom_range(0, 99) < 12) ? ACT_FLUSH : ACT_WRITE;
      sel = $urandom_range(0, 9);
      if (sel == 0) val = '1;
      else if (sel == 1) val = '0;
      else val = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 55) cnt = 7'($urandom_range(1, 12));
      else if (sel < 75) cnt = 7'($urandom_range(13, 32));
      else if (sel < 88) cnt = 7'($urandom_range(33, 64));
      else if (sel < 93) cnt = 7'd64;
      else if (sel < 97) cnt = 7'($urandom_range(65, 127));
      else cnt = 7'd0;
      queue_req(act, val, cnt);
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d items transferred (%0d flushes), %0d packed bytes checked",
             reqs_taken, flushes_taken, bytes_checked);
    $display("counts 0..127 with saturation, bursty sender, patterned output stalls");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
